// ===== rtl/largest_bordered_square_assert.svh =====
// Assertion macros for the bordered square block.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef LARGEST_BORDERED_SQUARE_ASSERT_SVH
`define LARGEST_BORDERED_SQUARE_ASSERT_SVH

// Same-cycle implication.
`define LBS_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LBS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lbs_pkg.sv =====
// Shared types and constants for the bordered square block.
// Used by lbs_ctrl and largest_bordered_square; no dependencies.
`default_nettype none

package lbs_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	localparam int SIDE_W    = 7;
	localparam int AREA_W    = 13;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'b1;

	localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

	typedef struct packed {
		logic              valid;
		logic [SIDE_W-1:0] side;
	} fin_t;

endpackage

`default_nettype wire

// ===== rtl/largest_bordered_square.sv =====
// Top level of the bordered square block: configuration registers, output register.
// Depends on lbs_pkg and lbs_ctrl.
//
// Usage:
//   Pixels stream in row-major order on pixel/pixel_valid/pixel_stall; a word
//   is taken at a clock edge with pixel_valid high and pixel_stall low.
//   image_rows (index 0) and image_cols (index 1) are written through
//   cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high. Zero is
//   treated as 1 and values above the maximum as the maximum.
//   After the last pixel of an image one result word (side, area) appears on
//   result_valid/result_stall and the position and best side clear.
//   A clear pixel passes through the run update and step states; a set pixel
//   also probes candidate sides, largest first, until one fits or side 1 misses
//   (at most the smaller of its left and up runs); each probe is one read pair
//   of the left-run and up-run RAMs followed by one compare.
//   The result is registered and shows in the cycle after the last pixel's step.
//   A stalled result holds; the next image streams in meanwhile and only its
//   own last pixel waits until the held result is taken.
//   Reset clears position, best side and result valid, and sets both size
//   registers to 64. The run RAMs are not cleared and need no clearing pass.
`default_nettype none

module largest_bordered_square #(
	parameter int MAX_ROWS = lbs_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = lbs_pkg::DEF_MAX_COLS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pixel_valid,
	output logic                                 pixel_stall,
	input  wire logic                            pixel,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output logic [lbs_pkg::SIDE_W-1:0]           side,
	output logic [lbs_pkg::AREA_W-1:0]           area,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [lbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lbs_pkg::CFG_W-1:0]       cfg_data
);

	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int CCW = $clog2(MAX_COLS + 1);
	localparam int PW  = 2 * lbs_pkg::SIDE_W;

	logic [lbs_pkg::CFG_W-1:0]  rows_q;
	logic [lbs_pkg::CFG_W-1:0]  cols_q;
	logic [RCW-1:0]             rows_eff;
	logic [CCW-1:0]             cols_eff;
	logic                       out_valid_q;
	logic [lbs_pkg::SIDE_W-1:0] side_q;
	logic [lbs_pkg::AREA_W-1:0] area_q;
	lbs_pkg::fin_t              fin;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= lbs_pkg::CFG_SIZE_RESET;
			cols_q <= lbs_pkg::CFG_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lbs_pkg::REG_IMAGE_ROWS: rows_q <= cfg_data;
				lbs_pkg::REG_IMAGE_COLS: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (rows_q == '0) begin
			rows_eff = RCW'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			rows_eff = RCW'(MAX_ROWS);
		end else begin
			rows_eff = RCW'(rows_q);
		end
		if (cols_q == '0) begin
			cols_eff = CCW'(1);
		end else if (int'(cols_q) > MAX_COLS) begin
			cols_eff = CCW'(MAX_COLS);
		end else begin
			cols_eff = CCW'(cols_q);
		end
	end

	lbs_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel       (pixel),
		.pixel_stall (pixel_stall),
		.rows        (rows_eff),
		.cols        (cols_eff),
		.out_busy    (out_valid_q),
		.fin         (fin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid) begin
			side_q <= fin.side;
			area_q <= lbs_pkg::AREA_W'(PW'(fin.side) * PW'(fin.side));
		end
	end

	assign result_valid = out_valid_q;
	assign side         = side_q;
	assign area         = area_q;

endmodule

`default_nettype wire

// ===== rtl/lbs_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; contents are undefined until written.
`default_nettype none

module lbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lbs_ctrl.sv =====
// Sequencer and run datapath: builds left/up runs and probes candidate sides.
// Depends on lbs_pkg, lbs_ram and largest_bordered_square_assert.svh.
`default_nettype none
`include "largest_bordered_square_assert.svh"

module lbs_ctrl #(
	parameter int MAX_ROWS = lbs_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = lbs_pkg::DEF_MAX_COLS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           pixel_valid,
	input  wire logic                           pixel,
	output logic                                pixel_stall,
	input  wire logic [$clog2(MAX_ROWS+1)-1:0]  rows,
	input  wire logic [$clog2(MAX_COLS+1)-1:0]  cols,
	input  wire logic                           out_busy,
	output lbs_pkg::fin_t                       fin
);

	localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RCW  = $clog2(MAX_ROWS + 1);
	localparam int CCW  = $clog2(MAX_COLS + 1);
	localparam int KMAX = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int KW   = $clog2(KMAX + 1);
	localparam int EW   = ((RCW > CCW) ? RCW : CCW) + 1;
	localparam int LD   = MAX_ROWS * MAX_COLS;
	localparam int LAW  = (LD > 1) ? $clog2(LD) : 1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CALC  = 5'b00010,
		ST_PROBE = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_STEP  = 5'b10000
	} state_t;

	state_t          state_q;
	logic [RW-1:0]   r_q;
	logic [CW-1:0]   c_q;
	logic            pix_q;
	logic [CCW-1:0]  last_lrun_q;
	logic [KW-1:0]   k_q;
	logic [KW-1:0]   best_q;

	logic [CCW-1:0]  left_rd;
	logic [RCW-1:0]  up_rd;

	logic [EW-1:0]   lrun_n;
	logic [EW-1:0]   urun_n;
	logic [EW-1:0]   k0;
	logic [EW-1:0]   top_e;
	logic [EW-1:0]   lft_e;
	logic            hit;
	logic [EW-1:0]   c_next;
	logic [EW-1:0]   r_next;
	logic            img_end;

	logic            accept;
	logic            left_we;
	logic            up_we;
	logic            left_re;
	logic            up_re;
	logic [LAW-1:0]  left_waddr;
	logic [LAW-1:0]  left_raddr;
	logic [CW-1:0]   up_raddr;

	assign accept      = pixel_valid && !pixel_stall;
	assign pixel_stall = (state_q != ST_IDLE);

	always_comb begin
		if (!pix_q) begin
			lrun_n = '0;
		end else if (c_q == '0) begin
			lrun_n = EW'(1);
		end else if (EW'(last_lrun_q) + EW'(1) > EW'(MAX_COLS)) begin
			lrun_n = EW'(MAX_COLS);
		end else begin
			lrun_n = EW'(last_lrun_q) + EW'(1);
		end

		if (!pix_q) begin
			urun_n = '0;
		end else if (r_q == '0) begin
			urun_n = EW'(1);
		end else if (EW'(up_rd) + EW'(1) > EW'(MAX_ROWS)) begin
			urun_n = EW'(MAX_ROWS);
		end else begin
			urun_n = EW'(up_rd) + EW'(1);
		end

		k0 = (lrun_n < urun_n) ? lrun_n : urun_n;
		if (k0 > EW'(r_q) + EW'(1)) begin
			k0 = EW'(r_q) + EW'(1);
		end
		if (k0 > EW'(c_q) + EW'(1)) begin
			k0 = EW'(c_q) + EW'(1);
		end
	end

	assign top_e = EW'(r_q) + EW'(1) - EW'(k_q);
	assign lft_e = EW'(c_q) + EW'(1) - EW'(k_q);
	assign hit   = (EW'(left_rd) >= EW'(k_q)) && (EW'(up_rd) >= EW'(k_q));

	always_comb begin
		c_next = EW'(c_q) + EW'(1);
		r_next = EW'(r_q);
		if (c_next >= EW'(cols)) begin
			c_next = '0;
			r_next = EW'(r_q) + EW'(1);
		end
		img_end = (r_next >= EW'(rows));
	end

	assign left_waddr = LAW'(LAW'(r_q) * LAW'(MAX_COLS)) + LAW'(c_q);
	assign left_raddr = LAW'(LAW'(RW'(top_e)) * LAW'(MAX_COLS)) + LAW'(c_q);
	assign up_raddr   = (state_q == ST_PROBE) ? CW'(lft_e) : c_q;

	assign left_we = (state_q == ST_CALC);
	assign up_we   = (state_q == ST_CALC);
	assign left_re = (state_q == ST_PROBE);
	assign up_re   = accept || (state_q == ST_PROBE);

	lbs_ram #(
		.WIDTH (CCW),
		.DEPTH (LD)
	) u_left_ram (
		.clk   (clk),
		.we    (left_we),
		.waddr (left_waddr),
		.wdata (CCW'(lrun_n)),
		.re    (left_re),
		.raddr (left_raddr),
		.rdata (left_rd)
	);

	lbs_ram #(
		.WIDTH (RCW),
		.DEPTH (MAX_COLS)
	) u_up_ram (
		.clk   (clk),
		.we    (up_we),
		.waddr (c_q),
		.wdata (RCW'(urun_n)),
		.re    (up_re),
		.raddr (up_raddr),
		.rdata (up_rd)
	);

	always_comb begin
		fin.valid = (state_q == ST_STEP) && img_end && !out_busy;
		fin.side  = lbs_pkg::SIDE_W'(best_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			best_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (k0 == '0) begin
						state_q <= ST_STEP;
					end else begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (hit) begin
						if (k_q > best_q) begin
							best_q <= k_q;
						end
						state_q <= ST_STEP;
					end else if (k_q == KW'(1)) begin
						state_q <= ST_STEP;
					end else begin
						state_q <= ST_PROBE;
					end
				end
				ST_STEP: begin
					if (img_end) begin
						if (!out_busy) begin
							r_q     <= '0;
							c_q     <= '0;
							best_q  <= '0;
							state_q <= ST_IDLE;
						end
					end else begin
						r_q     <= RW'(r_next);
						c_q     <= CW'(c_next);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= pixel;
		end
		if (state_q == ST_CALC) begin
			last_lrun_q <= CCW'(lrun_n);
			k_q         <= KW'(k0);
		end else if (state_q == ST_CHECK) begin
			k_q <= k_q - KW'(1);
		end
	end

	`LBS_ASSERT_NEXT(a_accept_to_calc, pixel_valid && !pixel_stall, state_q == ST_CALC, "accepted pixel did not start run update")
	`LBS_ASSERT_IMPL(a_probe_side_nonzero, state_q == ST_PROBE, k_q != '0, "probe issued with zero side")
	`LBS_ASSERT_IMPL(a_probe_in_bounds, state_q == ST_CHECK, (EW'(k_q) <= EW'(r_q) + EW'(1)) && (EW'(k_q) <= EW'(c_q) + EW'(1)), "candidate side exceeds position")
	`LBS_ASSERT_IMPL(a_fin_has_room, fin.valid, !out_busy, "result produced into a full output register")

endmodule

`default_nettype wire
